// ===== sv/cva_pkg.sv =====
// ----------------------------------------------------------------------------
// cva_pkg
// Shared constants, codes, types and the sigmoid table for the streaming
// 1-D convolution and activation block.
// ----------------------------------------------------------------------------
`default_nettype none

package cva_pkg;

    // Datapath sizes.
    localparam int TAPS      = 8;
    localparam int TAP_IDX_W = $clog2(TAPS);
    localparam int KLEN_W    = 4;
    localparam int SAMPLE_W  = 16;
    localparam int PROD_W    = 2 * SAMPLE_W;
    localparam int ACC_W     = PROD_W + TAP_IDX_W + 1;
    localparam int ROW_W     = 12;
    localparam int MAX_ROW   = 4096;
    localparam int OUT_CNT_W = ROW_W + 1;
    localparam int POS_W     = 19;
    localparam int FRAC_W    = 12;

    localparam logic [ROW_W-1:0] POS_LIMIT = ROW_W'(MAX_ROW - 1);

    // Configuration port.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_ROW_LENGTH      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KERNEL_LEN      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_SIZE       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PAD_COUNT       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ACTIVATION_MODE = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_BIAS_VALUE      = 3'd5;

    // Activation selection codes.
    localparam logic [1:0] ACT_SIGMOID  = 2'd0;
    localparam logic [1:0] ACT_RELU     = 2'd1;
    localparam logic [1:0] ACT_IDENTITY = 2'd2;

    // Input item kinds.
    localparam logic REQ_SAMPLE = 1'b0;
    localparam logic REQ_TAP    = 1'b1;

    // Stream port widths.
    localparam int S_DATA_W = 40;
    localparam int M_DATA_W = 32;

    // Sigmoid table.
    localparam int SIG_ENTRIES = 256;
    localparam int SIG_ADDR_W  = $clog2(SIG_ENTRIES);
    localparam logic [63:0] Q24_ONE = 64'd1 << 24;

    typedef logic [SIG_ENTRIES-1:0][SAMPLE_W-1:0] sig_table_t;

    // Per-result bookkeeping that travels with the arithmetic.
    typedef struct packed {
        logic [ROW_W-1:0] index;
        logic             row_done;
    } cva_meta_t;

    // Rounded and saturated sum with its bookkeeping.
    typedef struct packed {
        logic signed [SAMPLE_W-1:0] value;
        logic                       sat;
        cva_meta_t                  meta;
    } cva_res_t;

    // Unsigned quotient by shift and subtract; used only while the table is
    // built at elaboration.
    function automatic logic [63:0] udiv64(input logic [63:0] num,
                                           input logic [63:0] den);
        logic [64:0] rem;
        logic [63:0] quo;
        rem = '0;
        quo = '0;
        for (int b = 63; b >= 0; b--)
        begin
            rem = {rem[63:0], num[b]};
            if (rem >= {1'b0, den})
            begin
                rem    = rem - {1'b0, den};
                quo[b] = 1'b1;
            end
        end
        return quo;
    endfunction

    // Builds the table at elaboration: a Q24 exponential series on x/8,
    // three squarings, then a rounded quotient into Q4.12.
    function automatic sig_table_t build_sig_table();
        sig_table_t  tbl;
        logic [63:0] u;
        logic [63:0] z;
        logic [63:0] e;
        logic [63:0] term;
        logic [63:0] den;
        int          t;
        for (int i = 0; i < SIG_ENTRIES; i++)
        begin
            t    = 2 * i + 1 - SIG_ENTRIES;
            u    = 64'((t < 0) ? -t : t);
            z    = (u << 24) >> SIG_ADDR_W;
            e    = Q24_ONE;
            term = Q24_ONE;
            for (int n = 1; n <= 24; n++)
            begin
                term = udiv64((term * z) >> 24, 64'(n));
                e    = e + term;
            end
            for (int n = 0; n < 3; n++)
            begin
                e = (e * e + (Q24_ONE >> 1)) >> 24;
            end
            den = e + Q24_ONE;
            if (t >= 0)
            begin
                tbl[i] = SAMPLE_W'(udiv64(64'd4096 * e + (den >> 1), den));
            end
            else
            begin
                tbl[i] = SAMPLE_W'(udiv64(64'd4096 * Q24_ONE + (den >> 1), den));
            end
        end
        return tbl;
    endfunction

    localparam sig_table_t SIG_TABLE = build_sig_table();

endpackage

`default_nettype wire

// ===== sv/cva_mac.sv =====
// ----------------------------------------------------------------------------
// cva_mac
// Three-stage multiply, accumulate, round and saturate pipeline for one
// convolution output per item.
// ----------------------------------------------------------------------------
`default_nettype none

module cva_mac
(
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 in_valid,
    output logic                                      in_ready,
    input  wire logic signed [cva_pkg::SAMPLE_W-1:0]  samp [cva_pkg::TAPS],
    input  wire logic signed [cva_pkg::SAMPLE_W-1:0]  taps [cva_pkg::TAPS],
    input  wire logic signed [cva_pkg::SAMPLE_W-1:0]  bias,
    input  wire cva_pkg::cva_meta_t                   in_meta,
    output logic                                      out_valid,
    input  wire logic                                 out_ready,
    output cva_pkg::cva_res_t                         out_res
);

    localparam int HALF = cva_pkg::TAPS / 2;

    logic                                    s1_valid_reg;
    logic signed [cva_pkg::PROD_W-1:0]       s1_prod_reg [cva_pkg::TAPS];
    logic signed [cva_pkg::SAMPLE_W-1:0]     s1_bias_reg;
    cva_pkg::cva_meta_t                      s1_meta_reg;

    logic                                    s2_valid_reg;
    logic signed [cva_pkg::ACC_W-1:0]        s2_sum_a_reg;
    logic signed [cva_pkg::ACC_W-1:0]        s2_sum_b_reg;
    cva_pkg::cva_meta_t                      s2_meta_reg;

    logic                                    s3_valid_reg;
    cva_pkg::cva_res_t                       s3_res_reg;

    logic                                    s1_ready;
    logic                                    s2_ready;
    logic                                    s3_ready;
    logic signed [cva_pkg::ACC_W-1:0]        sum_a_next;
    logic signed [cva_pkg::ACC_W-1:0]        sum_b_next;
    logic signed [cva_pkg::ACC_W-1:0]        acc;
    logic signed [cva_pkg::ACC_W-1:0]        rnd;
    cva_pkg::cva_res_t                       res_next;

    // A stage may take a new item when it is empty or its item moves on.
    assign s3_ready = !s3_valid_reg || out_ready;
    assign s2_ready = !s2_valid_reg || s3_ready;
    assign s1_ready = !s1_valid_reg || s2_ready;
    assign in_ready = s1_ready;

    // Stage 1: one product per tap.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (s1_ready)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_ready && in_valid)
        begin
            for (int k = 0; k < cva_pkg::TAPS; k++)
            begin
                s1_prod_reg[k] <= samp[k] * taps[k];
            end
            s1_bias_reg <= bias;
            s1_meta_reg <= in_meta;
        end
    end

    // Stage 2: two partial sums, the bias scaled to Q8.24 goes in the first.
    always_comb
    begin
        sum_a_next = cva_pkg::ACC_W'(s1_bias_reg) <<< cva_pkg::FRAC_W;
        sum_b_next = '0;
        for (int k = 0; k < HALF; k++)
        begin
            sum_a_next = sum_a_next + cva_pkg::ACC_W'(s1_prod_reg[k]);
        end
        for (int k = HALF; k < cva_pkg::TAPS; k++)
        begin
            sum_b_next = sum_b_next + cva_pkg::ACC_W'(s1_prod_reg[k]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (s2_ready)
        begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_ready && s1_valid_reg)
        begin
            s2_sum_a_reg <= sum_a_next;
            s2_sum_b_reg <= sum_b_next;
            s2_meta_reg  <= s1_meta_reg;
        end
    end

    // Stage 3: final add, round half up to Q4.12 and clip to 16 bits.
    always_comb
    begin
        acc           = s2_sum_a_reg + s2_sum_b_reg;
        rnd           = (acc + cva_pkg::ACC_W'(2048)) >>> cva_pkg::FRAC_W;
        res_next.meta = s2_meta_reg;
        if (rnd > cva_pkg::ACC_W'(32767))
        begin
            res_next.value = 16'sh7FFF;
            res_next.sat   = 1'b1;
        end
        else if (rnd < -cva_pkg::ACC_W'(32768))
        begin
            res_next.value = -16'sh8000;
            res_next.sat   = 1'b1;
        end
        else
        begin
            res_next.value = rnd[cva_pkg::SAMPLE_W-1:0];
            res_next.sat   = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_valid_reg <= 1'b0;
        end
        else if (s3_ready)
        begin
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s3_ready && s2_valid_reg)
        begin
            s3_res_reg <= res_next;
        end
    end

    assign out_valid = s3_valid_reg;
    assign out_res   = s3_res_reg;

endmodule

`default_nettype wire

// ===== sv/conv1d_activation_stream.sv =====
// ----------------------------------------------------------------------------
// conv1d_activation_stream
// Strided, zero-padded 1-D convolution over streamed Q4.12 rows, with bias,
// saturation and a sigmoid, ReLU or identity activation.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake          Payload
//  s_*       in         s_tvalid/s_tready  s_tdata: sample, tap_index, tap_value
//                                          s_tuser: req_type
//  m_*       out        m_tvalid/m_tready  m_tdata: out_value, out_index
//                                          m_tuser: saturated, m_tlast: row_done
//  cfg_*     in         cfg_we             cfg_index, cfg_data
//
//  An item is taken every cycle while each sample yields at most one result
//  and the output is not stalled; a sample with n results holds s_tready
//  low until its last result is emitted, since the emit stage steps through
//  its outputs one per cycle unless stalled. Results pass the MAC stages
//  into the output register. Reset clears the control state and the taps,
//  and loads the register defaults; no clearing pass is needed. A stalled
//  m_tready fills the pipeline, then stops the emit stage and the input.
//
`default_nettype none

module conv1d_activation_stream
(
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    // Input items.
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    // [15:0] sample, [18:16] tap_index, [34:19] tap_value, [39:35] zero
    input  wire logic [cva_pkg::S_DATA_W-1:0]       s_tdata,
    // [0] req_type
    input  wire logic                               s_tuser,
    // Result items.
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    // [15:0] out_value, [27:16] out_index, [31:28] zero
    output logic [cva_pkg::M_DATA_W-1:0]            m_tdata,
    // [0] saturated
    output logic                                    m_tuser,
    output logic                                    m_tlast,
    // Configuration writes.
    input  wire logic                               cfg_we,
    input  wire logic [cva_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire logic [cva_pkg::CFG_DATA_W-1:0]     cfg_data
);

    localparam int SW = cva_pkg::SAMPLE_W;
    localparam int PW = cva_pkg::POS_W;

    // Configuration registers.
    logic [cva_pkg::ROW_W-1:0]       len_reg;
    logic [cva_pkg::KLEN_W-1:0]      klen_reg;
    logic [3:0]                      step_reg;
    logic [2:0]                      pad_reg;
    logic [1:0]                      mode_reg;
    logic signed [SW-1:0]            bias_reg;

    // Row state.
    logic signed [SW-1:0]            win_reg  [cva_pkg::TAPS];
    logic signed [SW-1:0]            taps_reg [cva_pkg::TAPS];
    logic [cva_pkg::ROW_W-1:0]       pos_reg;
    logic [cva_pkg::OUT_CNT_W-1:0]   next_out_reg;

    // Emit stage.
    logic                            j_active_reg;
    logic                            j_last_reg;
    logic [cva_pkg::ROW_W-1:0]       j_p_reg;
    logic [cva_pkg::OUT_CNT_W-1:0]   j_o_reg;
    logic [2:0]                      j_n_reg;
    logic signed [PW-1:0]            j_base_reg;

    // Output register.
    logic                            out_valid_reg;
    logic signed [SW-1:0]            out_value_reg;
    logic [cva_pkg::ROW_W-1:0]       out_index_reg;
    logic                            out_last_reg;
    logic                            out_sat_reg;

    logic                            req_type_in;
    logic signed [SW-1:0]            sample_in;
    logic [cva_pkg::TAP_IDX_W-1:0]   tap_index_in;
    logic signed [SW-1:0]            tap_value_in;
    logic                            s_acc;
    logic                            acc_sample;
    logic                            acc_tap;
    logic                            last_in;
    logic [cva_pkg::ROW_W-1:0]       pos_next;

    logic [cva_pkg::KLEN_W-1:0]      k_eff;
    logic [3:0]                      s_eff;
    logic signed [PW-1:0]            len_ext;
    logic signed [PW-1:0]            pad_ext;
    logic signed [PW-1:0]            step_ext;
    logic signed [PW-1:0]            lim;
    logic signed [PW-1:0]            p_ext;
    logic signed [PW-1:0]            wend;
    logic signed [PW-1:0]            wend2;
    logic                            cond_cur;
    logic                            cond_nxt;
    logic                            final_o;
    logic                            emit;
    logic                            j_done;
    logic [cva_pkg::OUT_CNT_W-1:0]   o_after;
    logic [cva_pkg::OUT_CNT_W-1:0]   o_in;
    logic [16:0]                     idle_prod;
    logic signed [PW-1:0]            base_idle;
    logic signed [PW-1:0]            base_in;

    logic signed [PW-1:0]            sel_idx  [cva_pkg::TAPS];
    logic signed [PW-1:0]            sel_dist [cva_pkg::TAPS];
    logic signed [SW-1:0]            samp_sel [cva_pkg::TAPS];

    logic                            mac_in_valid;
    logic                            mac_in_ready;
    cva_pkg::cva_meta_t              mac_meta;
    logic                            mac_out_valid;
    logic                            out_take;
    cva_pkg::cva_res_t               mac_res;
    logic signed [SW-1:0]            act_value;

    // Input field decode.
    assign req_type_in  = s_tuser;
    assign sample_in    = s_tdata[15:0];
    assign tap_index_in = s_tdata[18:16];
    assign tap_value_in = s_tdata[34:19];

    assign s_acc      = s_tvalid && s_tready;
    assign acc_sample = s_acc && (req_type_in == cva_pkg::REQ_SAMPLE);
    assign acc_tap    = s_acc && (req_type_in == cva_pkg::REQ_TAP);

    // Configuration writes; indexes past the list are dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg  <= 12'd16;
            klen_reg <= 4'd5;
            step_reg <= 4'd1;
            pad_reg  <= 3'd0;
            mode_reg <= cva_pkg::ACT_RELU;
            bias_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                cva_pkg::CFG_ROW_LENGTH:      len_reg  <= cfg_data[11:0];
                cva_pkg::CFG_KERNEL_LEN:      klen_reg <= cfg_data[3:0];
                cva_pkg::CFG_STEP_SIZE:       step_reg <= cfg_data[3:0];
                cva_pkg::CFG_PAD_COUNT:       pad_reg  <= cfg_data[2:0];
                cva_pkg::CFG_ACTIVATION_MODE: mode_reg <= cfg_data[1:0];
                cva_pkg::CFG_BIAS_VALUE:      bias_reg <= cfg_data;
                default:                      ;
            endcase
        end
    end

    // Kernel length is clamped to 1..TAPS and a zero stride counts as 1.
    always_comb
    begin
        if (klen_reg == '0)
        begin
            k_eff = cva_pkg::KLEN_W'(1);
        end
        else if (klen_reg > cva_pkg::KLEN_W'(cva_pkg::TAPS))
        begin
            k_eff = cva_pkg::KLEN_W'(cva_pkg::TAPS);
        end
        else
        begin
            k_eff = klen_reg;
        end
        s_eff = (step_reg == 4'd0) ? 4'd1 : step_reg;
    end

    assign len_ext  = $signed({7'b0, len_reg});
    assign pad_ext  = $signed({16'b0, pad_reg});
    assign step_ext = $signed({15'b0, s_eff});
    // Last input position any window may touch, right padding included.
    assign lim      = len_ext + pad_ext - PW'(1);
    assign p_ext    = $signed({7'b0, j_p_reg});

    // Position bookkeeping for the arriving sample.
    assign last_in  = ({1'b0, pos_reg} + 13'd1) >= {1'b0, len_reg};

    always_comb
    begin
        if (last_in)
        begin
            pos_next = '0;
        end
        else if (pos_reg < cva_pkg::POS_LIMIT)
        begin
            pos_next = pos_reg + 1'b1;
        end
        else
        begin
            pos_next = pos_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
        end
        else if (acc_sample)
        begin
            pos_reg <= pos_next;
        end
    end

    // Sample window, newest in slot 0; it starts from zero on a new row.
    always_ff @(posedge clk)
    begin
        if (acc_sample)
        begin
            win_reg[0] <= sample_in;
            for (int j = 1; j < cva_pkg::TAPS; j++)
            begin
                win_reg[j] <= (pos_reg == '0) ? '0 : win_reg[j-1];
            end
        end
    end

    // Kernel taps.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int j = 0; j < cva_pkg::TAPS; j++)
            begin
                taps_reg[j] <= '0;
            end
        end
        else if (acc_tap)
        begin
            taps_reg[tap_index_in] <= tap_value_in;
        end
    end

    // Emit decision: window end of the current and of the following output.
    always_comb
    begin
        wend     = j_base_reg + $signed({15'b0, k_eff}) - PW'(1);
        wend2    = wend + step_ext;
        cond_cur = (wend <= lim) && (j_last_reg || (wend <= p_ext));
        cond_nxt = (wend2 <= lim) && (j_n_reg != 3'd7)
                   && (j_last_reg || (wend2 <= p_ext));
        final_o  = (wend <= lim) && (wend2 > lim);
    end

    assign mac_in_valid = j_active_reg && cond_cur;
    assign emit         = mac_in_valid && mac_in_ready;
    assign j_done       = j_active_reg && (!cond_cur || (emit && !cond_nxt));
    assign s_tready     = !j_active_reg || j_done;
    assign o_after      = emit ? (j_o_reg + 1'b1) : j_o_reg;

    // Start point of the next sample's output scan.
    assign idle_prod = {4'b0, next_out_reg} * {13'b0, s_eff};
    assign base_idle = $signed({2'b0, idle_prod}) - pad_ext;

    always_comb
    begin
        if (j_done)
        begin
            o_in    = j_last_reg ? '0 : o_after;
            base_in = j_last_reg ? -pad_ext
                                 : (emit ? (j_base_reg + step_ext) : j_base_reg);
        end
        else
        begin
            o_in    = next_out_reg;
            base_in = base_idle;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            next_out_reg <= '0;
        end
        else if (j_done)
        begin
            next_out_reg <= j_last_reg ? '0 : o_after;
        end
    end

    // Emit stage registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            j_active_reg <= 1'b0;
            j_last_reg   <= 1'b0;
            j_p_reg      <= '0;
            j_o_reg      <= '0;
            j_n_reg      <= '0;
            j_base_reg   <= '0;
        end
        else if (acc_sample)
        begin
            j_active_reg <= 1'b1;
            j_last_reg   <= last_in;
            j_p_reg      <= pos_reg;
            j_o_reg      <= o_in;
            j_n_reg      <= '0;
            j_base_reg   <= base_in;
        end
        else if (j_done)
        begin
            j_active_reg <= 1'b0;
        end
        else if (emit)
        begin
            j_o_reg    <= j_o_reg + 1'b1;
            j_n_reg    <= j_n_reg + 1'b1;
            j_base_reg <= j_base_reg + step_ext;
        end
    end

    // Window slot for each tap; taps outside the row or the kernel read zero.
    always_comb
    begin
        for (int k = 0; k < cva_pkg::TAPS; k++)
        begin
            sel_idx[k]  = j_base_reg + PW'(k);
            sel_dist[k] = p_ext - sel_idx[k];
            if ((k < int'(k_eff)) && (sel_idx[k] >= 0) && (sel_dist[k] >= 0)
                && (sel_dist[k] < PW'(cva_pkg::TAPS)) && (sel_idx[k] < len_ext))
            begin
                samp_sel[k] = win_reg[sel_dist[k][cva_pkg::TAP_IDX_W-1:0]];
            end
            else
            begin
                samp_sel[k] = '0;
            end
        end
    end

    assign mac_meta.index    = j_o_reg[cva_pkg::ROW_W-1:0];
    assign mac_meta.row_done = final_o || (j_last_reg && !cond_nxt);

    cva_mac u_mac
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (mac_in_valid),
        .in_ready  (mac_in_ready),
        .samp      (samp_sel),
        .taps      (taps_reg),
        .bias      (bias_reg),
        .in_meta   (mac_meta),
        .out_valid (mac_out_valid),
        .out_ready (out_take),
        .out_res   (mac_res)
    );

    // Activation on the saturated sum.
    always_comb
    begin
        case (mode_reg)
            cva_pkg::ACT_SIGMOID:
                act_value = cva_pkg::SIG_TABLE[{~mac_res.value[SW-1],
                    mac_res.value[SW-2:SW-cva_pkg::SIG_ADDR_W]}];
            cva_pkg::ACT_RELU:
                act_value = mac_res.value[SW-1] ? '0 : mac_res.value;
            default:
                act_value = mac_res.value;
        endcase
    end

    // Output register.
    assign out_take = !out_valid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_take)
        begin
            out_valid_reg <= mac_out_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_take && mac_out_valid)
        begin
            out_value_reg <= act_value;
            out_index_reg <= mac_res.meta.index;
            out_last_reg  <= mac_res.meta.row_done;
            out_sat_reg   <= mac_res.sat;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'b0, out_index_reg, out_value_reg};
    assign m_tuser  = out_sat_reg;
    assign m_tlast  = out_last_reg;

endmodule

`default_nettype wire

// ===== sv/cva_checker.sv =====
// ----------------------------------------------------------------------------
// cva_checker
// Port-level checks for conv1d_activation_stream, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module cva_checker
(
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               m_tvalid,
    input  wire logic                               m_tready,
    input  wire logic [cva_pkg::M_DATA_W-1:0]       m_tdata,
    input  wire logic                               m_tuser,
    input  wire logic                               m_tlast
);

    logic                        seen_reg;
    logic [cva_pkg::ROW_W-1:0]   prev_idx_reg;
    logic [cva_pkg::ROW_W-1:0]   cur_idx;

    assign cur_idx = m_tdata[27:16];

    // Index of the last delivered item.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg     <= 1'b0;
            prev_idx_reg <= '0;
        end
        else if (m_tvalid && m_tready)
        begin
            seen_reg     <= 1'b1;
            prev_idx_reg <= cur_idx;
        end
    end

    // Nothing is offered in the cycle after reset is seen.
    a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !m_tvalid)
        else $error("result offered during reset");

    // A stalled result stays offered with the same payload.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)
                                     && $stable(m_tuser) && $stable(m_tlast)))
        else $error("stalled result changed");

    // Output positions count up by one, or restart at zero on a new row.
    a_index_seq: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tready && seen_reg)
            |-> ((cur_idx == prev_idx_reg + 1'b1) || (cur_idx == '0)))
        else $error("output index out of sequence");

endmodule

bind conv1d_activation_stream cva_checker u_cva_checker (.*);

`default_nettype wire
